// ===== rtl/core/dgem_pkg.sv =====
// ----------------------------------------------------------------------------
// dgem_pkg
// Types, register indexes and the per-channel clamp shared by the diagonal
// emboss filter modules.
// ----------------------------------------------------------------------------
package dgem_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int FWIDTH_W   = 11;
  localparam int FHEIGHT_W  = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_SIZE   = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int BIAS       = 128;
  localparam int CHAN_MAX   = 255;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 13'd480;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_index_t REG_ENGRAVE_MODE = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [FWIDTH_W-1:0]  frame_width;
    logic [FHEIGHT_W-1:0] frame_height;
    logic                 engrave_mode;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic last;
  } pos_t;

  function automatic logic [CHAN_W-1:0] clamp_diff(input logic [CHAN_W-1:0] plus,
                                                   input logic [CHAN_W-1:0] minus);
    logic signed [CHAN_W+1:0] t;
    logic [CHAN_W-1:0]        res;
    t = $signed({2'b00, plus}) - $signed({2'b00, minus}) + (CHAN_W+2)'(BIAS);
    if (t < 0) begin
      res = '0;
    end else if (t > (CHAN_W+2)'(CHAN_MAX)) begin
      res = CHAN_W'(CHAN_MAX);
    end else begin
      res = t[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/dgem_pix_if.sv =====
// ----------------------------------------------------------------------------
// dgem_pix_if
// Pixel input channel: valid/ready with one BGR pixel per transfer.
// ----------------------------------------------------------------------------
interface dgem_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  input ready);
  modport sink (input valid, input blue_in, input green_in, input red_in,
                output ready);
endinterface

// ===== rtl/core/dgem_res_if.sv =====
// ----------------------------------------------------------------------------
// dgem_res_if
// Result channel: valid/ready with one filtered pixel per transfer.
// ----------------------------------------------------------------------------
interface dgem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_last;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output frame_last, input ready);
  modport sink (input valid, input blue_out, input green_out, input red_out,
                input frame_last, output ready);
endinterface

// ===== rtl/core/dgem_line_store.sv =====
// ----------------------------------------------------------------------------
// dgem_line_store
// One-row pixel memory, read-before-write at the current column, with a
// registered read and one further tap so the pixel two columns back of the
// previous row is at hand.
// ----------------------------------------------------------------------------
module dgem_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  dgem_pkg::pix_t wdata,
  output dgem_pkg::pix_t earlier
);
  import dgem_pkg::*;

  pix_t mem [DEPTH];
  pix_t rd_q;
  pix_t tap;

  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q <= '0;
      tap  <= '0;
    end else if (en) begin
      rd_q <= mem[addr];
      tap  <= rd_q;
    end
  end

  assign earlier = tap;

endmodule

// ===== rtl/core/dgem_ctrl.sv =====
// ----------------------------------------------------------------------------
// dgem_ctrl
// Column and row counters with frame-size saturation; gives the line-store
// address and whether the current transfer produces an interior result.
// ----------------------------------------------------------------------------
module dgem_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  dgem_pkg::cfg_t  cfg,
  input  logic            accept,
  output logic [CW-1:0]   col,
  output dgem_pkg::pos_t  pos
);
  import dgem_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]        col_q;
  logic [ROW_W-1:0]     row_q;
  logic [CW-1:0]        col_next;
  logic [ROW_W-1:0]     row_next;
  logic [WW-1:0]        w;
  logic [FHEIGHT_W-1:0] h;
  logic [CW-1:0]        c_t;
  logic [FHEIGHT_W-1:0] r_t;
  logic [WW:0]          c_inc;
  logic [FHEIGHT_W-1:0] r_inc;

  always_comb begin
    if (32'(cfg.frame_width) < MIN_SIZE) begin
      w = WW'(MIN_SIZE);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.frame_width);
    end
    if (32'(cfg.frame_height) < MIN_SIZE) begin
      h = FHEIGHT_W'(MIN_SIZE);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      h = FHEIGHT_W'(MAX_HEIGHT);
    end else begin
      h = cfg.frame_height;
    end
  end

  // wrap held counters against the current size first
  always_comb begin
    if (WW'(col_q) >= w) begin
      c_t = '0;
      r_t = {1'b0, row_q} + FHEIGHT_W'(1);
    end else begin
      c_t = col_q;
      r_t = {1'b0, row_q};
    end
    if (r_t >= h) begin
      r_t = '0;
    end
  end

  always_comb begin
    c_inc = {1'b0, WW'(c_t)} + (WW+1)'(1);
    r_inc = r_t + FHEIGHT_W'(1);
    if (c_inc >= {1'b0, w}) begin
      col_next = '0;
      row_next = (r_inc >= h) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r_t[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_next;
      row_q <= row_next;
    end
  end

  assign col      = c_t;
  assign pos.emit = (r_t >= FHEIGHT_W'(2)) && (WW'(c_t) >= WW'(2));
  assign pos.last = (r_t == h - FHEIGHT_W'(1)) && (WW'(c_t) == w - WW'(1));

endmodule

// ===== rtl/core/dgem_out_stage.sv =====
// ----------------------------------------------------------------------------
// dgem_out_stage
// Per-channel difference and clamp into the result register; decouples the
// result channel from the pixel channel.
// ----------------------------------------------------------------------------
module dgem_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dgem_pkg::pos_t  pos,
  input  logic            engrave,
  input  dgem_pkg::pix_t  later,
  input  dgem_pkg::pix_t  earlier,
  output logic            free,
  dgem_res_if.source      res
);
  import dgem_pkg::*;

  logic              valid;
  logic [CHAN_W-1:0] ch_res [3];
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] red;
  logic              last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_res[i] = engrave ? clamp_diff(earlier[i*CHAN_W +: CHAN_W], later[i*CHAN_W +: CHAN_W])
                          : clamp_diff(later[i*CHAN_W +: CHAN_W], earlier[i*CHAN_W +: CHAN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= pos.emit;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos.emit) begin
      blue  <= ch_res[0];
      green <= ch_res[1];
      red   <= ch_res[2];
      last  <= pos.last;
    end
  end

  assign free           = !valid || res.ready;
  assign res.valid      = valid;
  assign res.blue_out   = blue;
  assign res.green_out  = green;
  assign res.red_out    = red;
  assign res.frame_last = last;

endmodule

// ===== rtl/core/diagonal_emboss_filter.sv =====
// ----------------------------------------------------------------------------
// diagonal_emboss_filter
// Diagonal emboss / engrave over a BGR raster stream using one line store.
//
//   channel   dir   transfer                  payload
//   pixel     in    pixel.valid & ready       blue_in, green_in, red_in
//   result    out   result.valid & ready      blue_out, green_out, red_out,
//                                             frame_last
//   config    in    cfg_we                    cfg_index, cfg_data
//
// One pixel per cycle unless result stalls; pixel (y,x) and line-store pixel
// (y-1,x-2) give a result that is registered in the result register; the
// line-store read passes through the read register and the tap before use.
// Reset clears counters, taps and config; line store is not cleared.
// pixel.ready drops only while a result waits with result.ready low.
// ----------------------------------------------------------------------------
module diagonal_emboss_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  dgem_pkg::cfg_index_t              cfg_index,
  input  logic [dgem_pkg::CFG_DATA_W-1:0]   cfg_data,
  dgem_pix_if.sink                          pixel,
  dgem_res_if.source                        result
);
  import dgem_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  cfg_t          cfg;
  logic          accept;
  logic          free;
  logic [CW-1:0] col;
  pos_t          pos;
  pix_t          pix;
  pix_t          earlier;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FWIDTH_RESET;
      cfg.frame_height <= FHEIGHT_RESET;
      cfg.engrave_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[FHEIGHT_W-1:0];
        REG_ENGRAVE_MODE: cfg.engrave_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pixel.ready = free;
  assign accept      = pixel.valid && free;
  assign pix         = {pixel.red_in, pixel.green_in, pixel.blue_in};

  dgem_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .col    (col),
    .pos    (pos)
  );

  dgem_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .addr    (col),
    .wdata   (pix),
    .earlier (earlier)
  );

  dgem_out_stage u_out_stage (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pos     (pos),
    .engrave (cfg.engrave_mode),
    .later   (pix),
    .earlier (earlier),
    .free    (free),
    .res     (result)
  );

endmodule

// ===== rtl/core/dgem_checker.sv =====
// ----------------------------------------------------------------------------
// dgem_checker
// Port-level checks on the diagonal emboss filter: result handshake,
// ready coupling and result provenance.
// ----------------------------------------------------------------------------
module dgem_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_payload
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("result payload changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("pixel ready not tied to result register state");

  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without a pixel transfer");

endmodule

bind diagonal_emboss_filter dgem_checker u_dgem_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixel.valid),
  .in_ready    (pixel.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_payload ({result.frame_last, result.red_out, result.green_out, result.blue_out})
);
